[rtl/lzfd_pkg.sv]
package lzfd_pkg;

  localparam int unsigned OutSizeW      = 31;
  localparam int unsigned ConsW         = 31;
  localparam int unsigned LenW          = 6;
  localparam int unsigned OffW          = 12;
  localparam int unsigned WinSizeDef    = 4096;
  localparam int unsigned QueueDepthDef = 4;
  localparam logic [7:0]  SpaceByte     = 8'h20;

  localparam logic [1:0] StatusOk    = 2'd0;
  localparam logic [1:0] StatusOver  = 2'd1;
  localparam logic [1:0] StatusEmpty = 2'd2;

  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_LIT    = 2'd1,
    CMD_MATCH  = 2'd2,
    CMD_STATUS = 2'd3
  } cmd_kind_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       first;
    logic       final_req;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       out_byte;
    logic             has_byte;
    logic             done_res;
    logic [1:0]       status;
    logic [ConsW-1:0] consumed;
  } out_item_t;

  typedef struct packed {
    cmd_kind_e        kind;
    logic [7:0]       lit;
    logic [LenW-1:0]  len;
    logic [OffW-1:0]  off;
    logic [1:0]       status;
    logic [ConsW-1:0] consumed;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Extra distance bits for a distance byte, indexed by its high nibble.
  function automatic logic [2:0] extra_bits(logic [3:0] hi);
    logic [2:0] e;
    unique case (hi)
      4'd0, 4'd1:              e = 3'd1;
      4'd2, 4'd3, 4'd4:        e = 3'd2;
      4'd5, 4'd6, 4'd7, 4'd8:  e = 3'd3;
      4'd9, 4'd10, 4'd11:      e = 3'd4;
      4'd12, 4'd13, 4'd14:     e = 3'd5;
      default:                 e = 3'd6;
    endcase
    return e;
  endfunction

  // Upper six bits of the match offset.
  function automatic logic [5:0] pos_code(logic [7:0] d);
    logic [7:0] r;
    priority if (d < 8'd32)  r = 8'd0;
    else if (d < 8'd48)      r = 8'd1;
    else if (d < 8'd64)      r = 8'd2;
    else if (d < 8'd80)      r = 8'd3;
    else if (d < 8'd144)     r = 8'd4 + ((d - 8'd80) >> 3);
    else if (d < 8'd192)     r = 8'd12 + ((d - 8'd144) >> 2);
    else if (d < 8'd240)     r = 8'd24 + ((d - 8'd192) >> 1);
    else                     r = 8'd48 + (d - 8'd240);
    return r[5:0];
  endfunction

endpackage

[rtl/lzfd_queue.sv]
module lzfd_queue import lzfd_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDef
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  cmd_t    cmd_i,
  input  logic    pop_i,
  output cmd_t    cmd_o,
  output q_stat_t stat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            slot_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign cmd_o        = slot_q[rd_q];
  assign stat_o.full  = (cnt_q == CntW'(Depth));
  assign stat_o.empty = (cnt_q == '0);

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= cmd_i;
    end
  end

endmodule

[rtl/lzfd_front.sv]
module lzfd_front import lzfd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_data_i,
  input  logic                cfg_we_i,
  input  logic [OutSizeW-1:0] cfg_wdata_i,
  output logic                push_o,
  output cmd_t                cmd_o,
  input  q_stat_t             q_stat_i
);

  typedef enum logic [1:0] {
    F_IDLE  = 2'b01,
    F_PARSE = 2'b10
  } fstate_e;

  typedef enum logic [4:0] {
    T_FLAG  = 5'b00001,
    T_LIT   = 5'b00010,
    T_LEN   = 5'b00100,
    T_DIST  = 5'b01000,
    T_EXTRA = 5'b10000
  } tphase_e;

  fstate_e             st_q, st_d;
  tphase_e             ph_q, ph_d;
  logic [15:0]         bits_q, bits_d;
  logic [4:0]          cnt_q, cnt_d;
  logic [LenW-1:0]     len_q, len_d;
  logic [7:0]          dist_q, dist_d;
  logic [31:0]         ocnt_q, ocnt_d;
  logic [ConsW-1:0]    icnt_q, icnt_d;
  logic                fin_q, fin_d;
  logic                final_q, final_d;
  logic [OutSizeW-1:0] size_q;

  logic [4:0]  need;
  logic        have;
  logic [4:0]  rest_cnt;
  logic [15:0] rest_bits;
  logic [15:0] shifted;
  logic [7:0]  tk_val;
  logic [2:0]  ext_n;
  logic [13:0] dist_ext;

  assign in_stall_o = (st_q != F_IDLE) || q_stat_i.full;

  // Field extraction for the current phase, MSB first.
  always_comb begin
    ext_n = extra_bits(dist_q[7:4]);
    unique case (ph_q)
      T_FLAG:  need = 5'd1;
      T_LEN:   need = 5'd6;
      T_EXTRA: need = {2'b00, ext_n};
      default: need = 5'd8;
    endcase
    have      = (cnt_q >= need);
    rest_cnt  = cnt_q - need;
    shifted   = bits_q >> (cnt_q - need);
    tk_val    = 8'(shifted & ((16'd1 << need) - 16'd1));
    rest_bits = bits_q & ((16'd1 << rest_cnt) - 16'd1);
    dist_ext  = ({6'b0, dist_q} << ext_n) | {6'b0, tk_val};
  end

  always_comb begin
    st_d    = st_q;
    ph_d    = ph_q;
    bits_d  = bits_q;
    cnt_d   = cnt_q;
    len_d   = len_q;
    dist_d  = dist_q;
    ocnt_d  = ocnt_q;
    icnt_d  = icnt_q;
    fin_d   = fin_q;
    final_d = final_q;
    push_o  = 1'b0;
    cmd_o   = '0;
    unique case (st_q)
      F_IDLE: begin
        if (in_valid_i && !in_stall_o) begin
          final_d = in_data_i.final_req;
          if (in_data_i.first) begin
            push_o     = 1'b1;
            cmd_o.kind = CMD_START;
            ph_d       = T_FLAG;
            bits_d     = {8'h00, in_data_i.in_byte};
            cnt_d      = 5'd8;
            len_d      = '0;
            dist_d     = '0;
            ocnt_d     = '0;
            icnt_d     = ConsW'(1);
            fin_d      = 1'b0;
            st_d       = F_PARSE;
          end else if (!fin_q) begin
            bits_d = {bits_q[7:0], in_data_i.in_byte};
            cnt_d  = cnt_q + 5'd8;
            icnt_d = icnt_q + 1'b1;
            st_d   = F_PARSE;
          end
        end
      end
      F_PARSE: begin
        if (!q_stat_i.full) begin
          if (ph_q == T_FLAG && ocnt_q >= {1'b0, size_q}) begin
            push_o         = 1'b1;
            cmd_o.kind     = CMD_STATUS;
            cmd_o.status   = (ocnt_q == {1'b0, size_q}) ? StatusOk : StatusOver;
            cmd_o.consumed = icnt_q - ConsW'(cnt_q[4:3]);
            fin_d          = 1'b1;
            st_d           = F_IDLE;
          end else if (!have) begin
            // out of bits for this byte; close the stream if nothing follows
            if (final_q) begin
              push_o       = 1'b1;
              cmd_o.kind   = CMD_STATUS;
              cmd_o.status = StatusEmpty;
              fin_d        = 1'b1;
            end
            st_d = F_IDLE;
          end else begin
            bits_d = rest_bits;
            cnt_d  = rest_cnt;
            unique case (ph_q)
              T_FLAG: begin
                ph_d = tk_val[0] ? T_LEN : T_LIT;
              end
              T_LIT: begin
                push_o     = 1'b1;
                cmd_o.kind = CMD_LIT;
                cmd_o.lit  = tk_val;
                ocnt_d     = ocnt_q + 32'd1;
                ph_d       = T_FLAG;
              end
              T_LEN: begin
                len_d = tk_val[LenW-1:0];
                ph_d  = T_DIST;
              end
              T_DIST: begin
                dist_d = tk_val;
                ph_d   = T_EXTRA;
              end
              T_EXTRA: begin
                // drop zero-length matches here
                push_o     = (len_q != '0);
                cmd_o.kind = CMD_MATCH;
                cmd_o.len  = len_q;
                cmd_o.off  = {pos_code(dist_q), dist_ext[5:0]};
                ocnt_d     = ocnt_q + 32'(len_q);
                ph_d       = T_FLAG;
              end
              default: ph_d = T_FLAG;
            endcase
          end
        end
      end
      default: st_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= F_IDLE;
      ph_q    <= T_FLAG;
      bits_q  <= '0;
      cnt_q   <= '0;
      len_q   <= '0;
      dist_q  <= '0;
      ocnt_q  <= '0;
      icnt_q  <= '0;
      fin_q   <= 1'b0;
      final_q <= 1'b0;
      size_q  <= '0;
    end else begin
      st_q    <= st_d;
      ph_q    <= ph_d;
      bits_q  <= bits_d;
      cnt_q   <= cnt_d;
      len_q   <= len_d;
      dist_q  <= dist_d;
      ocnt_q  <= ocnt_d;
      icnt_q  <= icnt_d;
      fin_q   <= fin_d;
      final_q <= final_d;
      if (cfg_we_i) begin
        size_q <= cfg_wdata_i;
      end
    end
  end

endmodule

[rtl/lzfd_back.sv]
module lzfd_back import lzfd_pkg::*; #(
  parameter int unsigned WinSize = WinSizeDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cmd_t      cmd_i,
  input  q_stat_t   q_stat_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  localparam int unsigned AW = $clog2(WinSize);

  logic [7:0] win_mem [WinSize];

  logic             act_q;
  logic [AW-1:0]    src_q;
  logic [LenW-1:0]  rem_q;
  logic [AW-1:0]    ip_q;
  logic [AW-1:0]    wp_q;
  logic             full_q;
  logic             s2_valid_q;
  logic             s2_byte_q;
  logic             s2_fwd_q;
  logic             s2_hit_q;
  logic [7:0]       s2_data_q;
  logic [1:0]       s2_status_q;
  logic [ConsW-1:0] s2_cons_q;
  logic [7:0]       mem_rd_q;
  logic             out_valid_q;
  out_item_t        out_q;

  logic       drain;
  logic       drain_wr;
  logic       issue_ok;
  logic       issue_rd;
  logic       do_start;
  logic       do_lit;
  logic       do_match;
  logic       do_stat;
  logic [7:0] drain_byte;

  assign drain      = s2_valid_q && (!out_valid_q || !out_stall_i);
  assign drain_wr   = drain && s2_byte_q;
  assign issue_ok   = !s2_valid_q || drain;
  // entries not yet written in this stream read as spaces
  assign drain_byte = s2_fwd_q ? s2_data_q : (s2_hit_q ? mem_rd_q : SpaceByte);

  always_comb begin
    pop_o    = 1'b0;
    issue_rd = 1'b0;
    do_start = 1'b0;
    do_lit   = 1'b0;
    do_match = 1'b0;
    do_stat  = 1'b0;
    if (act_q) begin
      issue_rd = issue_ok;
    end else if (!q_stat_i.empty) begin
      unique case (cmd_i.kind)
        CMD_START: begin
          do_start = !s2_valid_q;
          pop_o    = !s2_valid_q;
        end
        CMD_LIT: begin
          do_lit = issue_ok;
          pop_o  = issue_ok;
        end
        CMD_MATCH: begin
          do_match = 1'b1;
          pop_o    = 1'b1;
        end
        CMD_STATUS: begin
          do_stat = issue_ok;
          pop_o   = issue_ok;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (drain_wr) begin
      win_mem[wp_q] <= drain_byte;
    end
    if (issue_rd) begin
      mem_rd_q <= win_mem[src_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q       <= 1'b0;
      src_q       <= '0;
      rem_q       <= '0;
      ip_q        <= '0;
      wp_q        <= '0;
      full_q      <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (do_start) begin
        ip_q   <= '0;
        wp_q   <= '0;
        full_q <= 1'b0;
      end else begin
        if (do_lit || issue_rd) begin
          ip_q <= ip_q + 1'b1;
        end
        if (drain_wr) begin
          wp_q <= wp_q + 1'b1;
          if (wp_q == AW'(WinSize - 1)) begin
            full_q <= 1'b1;
          end
        end
      end

      if (do_match) begin
        act_q <= 1'b1;
        src_q <= ip_q - AW'(cmd_i.off) - 1'b1;
        rem_q <= cmd_i.len;
      end else if (issue_rd) begin
        src_q <= src_q + 1'b1;
        rem_q <= rem_q - 1'b1;
        if (rem_q == LenW'(1)) begin
          act_q <= 1'b0;
        end
      end

      if (issue_rd || do_lit || do_stat) begin
        s2_valid_q <= 1'b1;
      end else if (drain) begin
        s2_valid_q <= 1'b0;
      end

      if (drain) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Second stage payload: a byte from the window or a literal, or a status.
  always_ff @(posedge clk_i) begin
    if (issue_rd) begin
      s2_byte_q <= 1'b1;
      // the byte written at this edge is the one being read
      s2_fwd_q  <= drain_wr && (src_q == wp_q);
      s2_data_q <= drain_byte;
      s2_hit_q  <= full_q || (src_q < wp_q);
    end else if (do_lit) begin
      s2_byte_q <= 1'b1;
      s2_fwd_q  <= 1'b1;
      s2_data_q <= cmd_i.lit;
      s2_hit_q  <= 1'b1;
    end else if (do_stat) begin
      s2_byte_q   <= 1'b0;
      s2_status_q <= cmd_i.status;
      s2_cons_q   <= cmd_i.consumed;
    end
    if (drain) begin
      out_q.has_byte <= s2_byte_q;
      out_q.done_res <= !s2_byte_q;
      out_q.out_byte <= s2_byte_q ? drain_byte : 8'h00;
      out_q.status   <= s2_byte_q ? StatusOk : s2_status_q;
      out_q.consumed <= s2_byte_q ? '0 : s2_cons_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[rtl/lzss_flag_bit_decoder.sv]
// LZSS decoder with a flag bit per token and a 4096-byte window of spaces at
// stream start. A packed byte is taken while idle, then the token parser
// completes one token field at a time from the buffered bits (flag,
// literal, length, distance byte, extra bits) until too few are left, and
// only then is the next byte taken; the parser also holds while its command
// queue is full. The output side runs from that queue: a match is set up and
// then gives one byte per cycle while the output is not stalled, paced by the
// single read port of the window memory and by the output register.
// Unwritten window entries are tracked with a fill pointer, so there is no
// clearing pass after reset or at a new stream.
module lzss_flag_bit_decoder import lzfd_pkg::*; #(
  parameter int unsigned WINDOW_SIZE = WinSizeDef,
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_data_o,
  input  logic                cfg_we_i,
  input  logic [OutSizeW-1:0] cfg_wdata_i
);

  logic    q_push;
  logic    q_pop;
  cmd_t    q_wr_cmd;
  cmd_t    q_rd_cmd;
  q_stat_t q_stat;

  lzfd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .push_o     (q_push),
    .cmd_o      (q_wr_cmd),
    .q_stat_i   (q_stat)
  );

  lzfd_queue #(
    .Depth(QUEUE_DEPTH)
  ) u_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(q_push),
    .cmd_i (q_wr_cmd),
    .pop_i (q_pop),
    .cmd_o (q_rd_cmd),
    .stat_o(q_stat)
  );

  lzfd_back #(
    .WinSize(WINDOW_SIZE)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (q_rd_cmd),
    .q_stat_i   (q_stat),
    .pop_o      (q_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_stat.full)
    else $error("command pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_stat.empty)
    else $error("command popped from an empty queue");

  a_accept_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> !q_stat.full)
    else $error("transfer accepted with no room for a start command");
`endif

endmodule
